// ===== hw/rtl/xcrc_pkg.sv =====
// Shared types, byte codes and the CRC-16 byte update for the XMODEM-CRC receiver.
package xcrc_pkg;

    localparam int unsigned IDX_W = 7;

    localparam logic [7:0]  BYTE_SOH = 8'h01;
    localparam logic [7:0]  BYTE_EOT = 8'h04;
    localparam logic [7:0]  BYTE_ACK = 8'h06;
    localparam logic [7:0]  BYTE_NAK = 8'h15;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [2:0] {
        EV_DATA  = 3'd0,
        EV_ACK   = 3'd1,
        EV_NAK   = 3'd2,
        EV_END   = 3'd3,
        EV_ABORT = 3'd4
    } t_event;

    typedef struct packed {
        t_event             kind;
        logic [7:0]         data;
        logic [IDX_W-1:0]   index;
        logic [7:0]         block;
    } t_result;

    // CRC-16/XMODEM, MSB first, one byte per call
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/xcrc_in_reg.sv =====
// Input register stage: holds one received byte until the engine takes it.
module xcrc_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    output logic       o_valid,
    output logic [7:0] o_byte,
    input  logic       i_take
);
    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end
endmodule

// ===== hw/rtl/xcrc_engine.sv =====
// Frame parser state, running CRC and result formation, one byte per cycle while i_fire is high.
module xcrc_engine #(
    parameter int unsigned BLOCK_BYTES = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_byte,
    output logic              o_res_valid,
    output xcrc_pkg::t_result o_res
);
    import xcrc_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_BYTES - 1);

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_NUMBER  = 3'd1,
        PH_COMPL   = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC_HI  = 3'd4,
        PH_CRC_LO  = 3'd5
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [IDX_W-1:0] r_count, n_count;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_crc_hi, n_crc_hi;
    logic [7:0]       r_block, n_block;
    logic             res_valid;
    t_result          res;

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_crc     = r_crc;
        n_crc_hi  = r_crc_hi;
        n_block   = r_block;
        res_valid = 1'b0;
        res.kind  = EV_ABORT;
        res.data  = 8'h00;
        res.index = '0;
        res.block = r_block;
        unique case (r_phase)
            PH_NUMBER: begin
                n_block = i_byte;
                n_phase = PH_COMPL;
            end
            PH_COMPL: n_phase = PH_PAYLOAD;
            PH_PAYLOAD: begin
                n_crc     = crc_feed(r_crc, i_byte);
                res_valid = 1'b1;
                res.kind  = EV_DATA;
                res.data  = i_byte;
                res.index = r_count;
                if (r_count >= LAST_IDX) begin
                    n_count = '0;
                    n_phase = PH_CRC_HI;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            PH_CRC_HI: begin
                n_crc_hi = i_byte;
                n_phase  = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                n_phase   = PH_START;
                res_valid = 1'b1;
                if ({r_crc_hi, i_byte} == r_crc) begin
                    res.kind = EV_ACK;
                    res.data = BYTE_ACK;
                end else begin
                    res.kind = EV_NAK;
                    res.data = BYTE_NAK;
                end
            end
            default: begin
                // frame start; unknown phase codes land here as well
                n_phase = PH_START;
                if (i_byte == BYTE_SOH) begin
                    n_count = '0;
                    n_crc   = '0;
                    n_phase = PH_NUMBER;
                end else if (i_byte == BYTE_EOT) begin
                    res_valid = 1'b1;
                    res.kind  = EV_END;
                    res.data  = BYTE_ACK;
                end else begin
                    res_valid = 1'b1;
                end
            end
        endcase
    end

    assign o_res_valid = i_fire && res_valid;
    assign o_res       = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_count  <= '0;
            r_crc    <= '0;
            r_crc_hi <= '0;
            r_block  <= '0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_crc    <= n_crc;
            r_crc_hi <= n_crc_hi;
            r_block  <= n_block;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LAST_IDX)
        else $error("payload count beyond block end");

    a_count_outside_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CRC_HI || r_phase == PH_CRC_LO) |-> r_count == '0)
        else $error("payload count not cleared after block");

    a_last_byte_to_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_phase == PH_PAYLOAD && r_count == LAST_IDX) |=> r_phase == PH_CRC_HI)
        else $error("last payload byte did not move to CRC");

    a_header_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_NUMBER || r_phase == PH_COMPL || r_phase == PH_CRC_HI) |-> !o_res_valid)
        else $error("result produced for a header or CRC high byte");
endmodule

// ===== hw/rtl/xcrc_out_reg.sv =====
// Result register: holds one result item until the downstream side takes it.
module xcrc_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  xcrc_pkg::t_result i_res,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_tready,
    output xcrc_pkg::t_result o_res
);
    import xcrc_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || i_tready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
        if (o_ready && i_load) begin
            r_res <= i_res;
        end
    end
endmodule

// ===== hw/rtl/xmodem_crc_block_receiver.sv =====
// XMODEM-CRC block receiver top level.
// Takes one received byte per item and produces at most one result item per byte:
// payload bytes as they arrive, then ACK or NAK for each block after its CRC-16
// (poly 0x1021, init 0, big-endian on the wire), ACK for EOT, abort for any other
// byte at frame start. The block number is kept for the result items; neither it
// nor its complement is checked.
// A byte passes through an input register, then the combinational parser and CRC
// update, then the result register; one byte is taken every cycle while the result
// side keeps up, and the result register is the only place that stalls the input.
module xmodem_crc_block_receiver #(
    parameter int unsigned BLOCK_BYTES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // data_byte[7:0], byte_index[14:8], block_number[22:15], 0
    output logic [2:0]  m_axis_tuser    // event_kind[2:0]
);
    import xcrc_pkg::*;

    logic       in_valid;
    logic [7:0] in_byte;
    logic       take;
    logic       out_ready;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    assign take = in_valid && out_ready;

    xcrc_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .o_valid (in_valid),
        .o_byte  (in_byte),
        .i_take  (take)
    );

    xcrc_engine #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (take),
        .i_byte      (in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    xcrc_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (res_valid),
        .i_res    (res),
        .o_ready  (out_ready),
        .o_valid  (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_res    (out_res)
    );

    assign m_axis_tuser = out_res.kind;
    assign m_axis_tdata = {1'b0, out_res.block, out_res.index, out_res.data};
endmodule
